@@ hw/rtl/rsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rsa_pkg
// Types and constants shared by the rectangle slot allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int MIN_DIM   = 2;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int LINK_W    = IDX_W + 1;
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int SUM_W     = 15;

    localparam logic [LINK_W-1:0] NO_LINK   = LINK_W'(MAX_SLOTS);
    localparam logic [DIM_W-1:0]  DIM_MAX   = DIM_W'(4096);
    localparam logic [SUM_W-1:0]  COORD_MAX = SUM_W'(4095);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FIT  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] REG_AW  = 2'd0;
    localparam logic [1:0] REG_AH  = 2'd1;
    localparam logic [1:0] REG_PAD = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_TEST,
        S_SPARE,
        S_SPLIT,
        S_UNLINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } t_slot;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] s;
        s = (v > COORD_MAX) ? COORD_MAX : v;
        return s[COORD_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

endpackage

@@ hw/rtl/rsa_store.sv @@
// ----------------------------------------------------------------------------
// rsa_store
// Slot rectangle memory and link memory, one write and one read port each.
// ----------------------------------------------------------------------------
module rsa_store (
    input  logic                       i_clk,
    input  logic                       i_slot_we,
    input  logic [rsa_pkg::IDX_W-1:0]  i_slot_waddr,
    input  rsa_pkg::t_slot             i_slot_wdata,
    input  logic [rsa_pkg::IDX_W-1:0]  i_slot_raddr,
    output rsa_pkg::t_slot             o_slot_rdata,
    input  logic                       i_link_we,
    input  logic [rsa_pkg::IDX_W-1:0]  i_link_waddr,
    input  logic [rsa_pkg::LINK_W-1:0] i_link_wdata,
    input  logic [rsa_pkg::IDX_W-1:0]  i_link_raddr,
    output logic [rsa_pkg::LINK_W-1:0] o_link_rdata
);

    rsa_pkg::t_slot             r_slot_mem [rsa_pkg::MAX_SLOTS];
    logic [rsa_pkg::LINK_W-1:0] r_link_mem [rsa_pkg::MAX_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_slot_we) begin
            r_slot_mem[i_slot_waddr] <= i_slot_wdata;
        end
        o_slot_rdata <= r_slot_mem[i_slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            r_link_mem[i_link_waddr] <= i_link_wdata;
        end
        o_link_rdata <= r_link_mem[i_link_raddr];
    end

endmodule

@@ hw/rtl/rectangle_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// rectangle_slot_allocator
// First-fit guillotine packer over a linked list of free slots in memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// request   in         i_start, o_busy, i_kind, i_req_width, i_req_height
// result    out        o_done, o_status, o_slot_x/y, o_slot_width/height
// config    in         psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// After reset and after each clear beat the link chain is rebuilt while busy
// is high. An allocate beat reads and then tests each free slot visited,
// then splits or unlinks the slot that fits, stops after the spare check
// when the store is full, or goes straight to done when nothing fits. The
// result strobe comes in the first cycle with busy low and lasts one cycle;
// it cannot be stalled.
// ----------------------------------------------------------------------------
module rectangle_slot_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_kind,
    input  logic [12:0] i_req_width,
    input  logic [12:0] i_req_height,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [11:0] o_slot_x,
    output logic [11:0] o_slot_y,
    output logic [12:0] o_slot_width,
    output logic [12:0] o_slot_height,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = rsa_pkg::IDX_W;
    localparam int LW = rsa_pkg::LINK_W;
    localparam int DW = rsa_pkg::DIM_W;
    localparam int SW = rsa_pkg::SUM_W;

    rsa_pkg::t_state r_state, n_state;
    logic [DW-1:0] r_aw, r_ah;
    logic          r_pad;
    logic [LW-1:0] r_head, n_head, r_spare, n_spare;
    logic [LW-1:0] r_cur, n_cur, r_prev, n_prev;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [DW:0]   r_pw, n_pw, r_ph, n_ph;
    rsa_pkg::t_slot r_fs, n_fs;
    logic [LW-1:0]  r_fnext, n_fnext;
    logic [1:0]    r_st, n_st;
    logic          r_done, n_done;

    logic          slot_we, link_we;
    logic [IW-1:0] slot_waddr, slot_raddr, link_waddr, link_raddr;
    rsa_pkg::t_slot slot_wdata, slot_rdata;
    logic [LW-1:0] link_wdata, link_rdata;

    logic          m_slot_we, m_link_we;
    logic [IW-1:0] m_slot_waddr, m_link_waddr;
    rsa_pkg::t_slot m_slot_wdata;
    logic [LW-1:0] m_link_wdata;

    logic [1:0]    r_st_q;
    logic          r_from_reset_q;

    logic          cfg_wr;
    logic [1:0]    reg_idx;
    logic [DW:0]   rem_w, rem_h;
    logic          fits, need_split;

    rsa_store u_store (
        .i_clk       (i_clk),
        .i_slot_we   (m_slot_we),
        .i_slot_waddr(m_slot_waddr),
        .i_slot_wdata(m_slot_wdata),
        .i_slot_raddr(slot_raddr),
        .o_slot_rdata(slot_rdata),
        .i_link_we   (m_link_we),
        .i_link_waddr(m_link_waddr),
        .i_link_wdata(m_link_wdata),
        .i_link_raddr(link_raddr),
        .o_link_rdata(link_rdata)
    );

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (reg_idx)
            rsa_pkg::REG_AW:  prdata = 32'(r_aw);
            rsa_pkg::REG_AH:  prdata = 32'(r_ah);
            rsa_pkg::REG_PAD: prdata = 32'(r_pad);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw  <= DW'(1024);
            r_ah  <= DW'(1024);
            r_pad <= 1'b1;
        end else if (cfg_wr) begin
            case (reg_idx)
                rsa_pkg::REG_AW:  r_aw  <= pwdata[DW-1:0];
                rsa_pkg::REG_AH:  r_ah  <= pwdata[DW-1:0];
                rsa_pkg::REG_PAD: r_pad <= pwdata[0];
                default:          ;
            endcase
        end
    end

    assign rem_w      = {1'b0, r_fs.w} - r_pw;
    assign rem_h      = {1'b0, r_fs.h} - r_ph;
    assign fits       = (r_pw <= {1'b0, slot_rdata.w}) && (r_ph <= {1'b0, slot_rdata.h});
    assign need_split = (rem_h >= (DW+1)'(rsa_pkg::MIN_DIM))
                     || (rem_w >= (DW+1)'(rsa_pkg::MIN_DIM));

    always_comb begin
        n_state = r_state;
        case (r_state)
            rsa_pkg::S_INIT:   if (r_cnt == LW'(rsa_pkg::MAX_SLOTS - 1)) begin
                                   n_state = rsa_pkg::S_DONE;
                               end
            rsa_pkg::S_IDLE:   if (i_start) begin
                                   if (i_kind) begin
                                       n_state = rsa_pkg::S_INIT;
                                   end else if (r_head == rsa_pkg::NO_LINK) begin
                                       n_state = rsa_pkg::S_DONE;
                                   end else begin
                                       n_state = rsa_pkg::S_READ;
                                   end
                               end
            rsa_pkg::S_READ:   n_state = rsa_pkg::S_TEST;
            rsa_pkg::S_TEST:   if (fits) begin
                                   n_state = rsa_pkg::S_SPARE;
                               end else if (link_rdata == rsa_pkg::NO_LINK
                                   || r_cnt == LW'(rsa_pkg::MAX_SLOTS - 1)) begin
                                   n_state = rsa_pkg::S_DONE;
                               end else begin
                                   n_state = rsa_pkg::S_READ;
                               end
            rsa_pkg::S_SPARE:  if (!need_split) begin
                                   n_state = rsa_pkg::S_UNLINK;
                               end else if (r_spare == rsa_pkg::NO_LINK) begin
                                   n_state = rsa_pkg::S_DONE;
                               end else begin
                                   n_state = rsa_pkg::S_SPLIT;
                               end
            rsa_pkg::S_SPLIT:  n_state = rsa_pkg::S_DONE;
            rsa_pkg::S_UNLINK: n_state = rsa_pkg::S_DONE;
            rsa_pkg::S_DONE:   n_state = rsa_pkg::S_IDLE;
            default:           n_state = rsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_spare = r_spare;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_cnt   = r_cnt;
        n_pw    = r_pw;
        n_ph    = r_ph;
        n_fs    = r_fs;
        n_fnext = r_fnext;
        n_st    = r_st;
        n_done  = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = r_cur[IW-1:0];
        slot_wdata = r_fs;
        slot_raddr = r_cur[IW-1:0];
        link_we    = 1'b0;
        link_waddr = r_cur[IW-1:0];
        link_wdata = rsa_pkg::NO_LINK;
        link_raddr = r_cur[IW-1:0];
        case (r_state)
            rsa_pkg::S_INIT: begin
                link_we    = 1'b1;
                link_waddr = r_cnt[IW-1:0];
                link_wdata = (r_cnt == '0 || r_cnt == LW'(rsa_pkg::MAX_SLOTS - 1))
                           ? rsa_pkg::NO_LINK : r_cnt + LW'(1);
                if (r_cnt == '0) begin
                    slot_we    = 1'b1;
                    slot_waddr = '0;
                    slot_wdata = '{x: '0, y: '0,
                                   w: rsa_pkg::sat_dim(r_aw), h: rsa_pkg::sat_dim(r_ah)};
                end
                n_cnt   = r_cnt + LW'(1);
                n_head  = '0;
                n_spare = LW'(1);
                n_st    = rsa_pkg::ST_OK;
                n_fs    = '0;
                n_pw    = '0;
                n_ph    = '0;
            end
            rsa_pkg::S_IDLE: begin
                n_cur  = r_head;
                n_prev = rsa_pkg::NO_LINK;
                n_cnt  = '0;
                n_pw   = (DW+1)'(i_req_width) + (DW+1)'({r_pad, 1'b0});
                n_ph   = (DW+1)'(i_req_height) + (DW+1)'({r_pad, 1'b0});
                n_st   = rsa_pkg::ST_FIT;
            end
            rsa_pkg::S_TEST: begin
                n_fs    = slot_rdata;
                n_fnext = link_rdata;
                if (!fits) begin
                    n_prev = r_cur;
                    n_cur  = link_rdata;
                    n_cnt  = r_cnt + LW'(1);
                end
                link_raddr = r_spare[IW-1:0];
            end
            rsa_pkg::S_SPARE: begin
                if (need_split && r_spare == rsa_pkg::NO_LINK) begin
                    n_st = rsa_pkg::ST_FULL;
                end
                link_raddr = r_spare[IW-1:0];
                n_cnt      = link_rdata;
            end
            rsa_pkg::S_SPLIT: begin
                slot_we    = 1'b1;
                slot_waddr = r_cur[IW-1:0];
                link_we    = 1'b1;
                link_waddr = r_cur[IW-1:0];
                link_wdata = r_spare;
                if (rem_h <= rem_w) begin
                    slot_wdata = '{x: r_fs.x,
                                   y: rsa_pkg::sat_coord(SW'(r_fs.y) + SW'(r_ph)),
                                   w: rsa_pkg::sat_dim(r_pw[DW-1:0]),
                                   h: rsa_pkg::sat_dim(rem_h[DW-1:0])};
                end else begin
                    slot_wdata = '{x: rsa_pkg::sat_coord(SW'(r_fs.x) + SW'(r_pw)),
                                   y: r_fs.y,
                                   w: rsa_pkg::sat_dim(rem_w[DW-1:0]),
                                   h: rsa_pkg::sat_dim(r_ph[DW-1:0])};
                end
                n_cur   = r_spare;
                n_spare = r_cnt;
                n_st    = rsa_pkg::ST_OK;
            end
            rsa_pkg::S_UNLINK: begin
                link_we    = 1'b1;
                link_waddr = r_cur[IW-1:0];
                link_wdata = r_spare;
                if (r_prev == rsa_pkg::NO_LINK) begin
                    n_head = r_fnext;
                end
                n_spare = r_cur;
                n_st    = rsa_pkg::ST_OK;
            end
            rsa_pkg::S_DONE: begin
                n_done = 1'b1;
            end
            default: ;
        endcase
    end

    // Second half of split and unlink: second child and predecessor link.
    logic          r_post, n_post;
    logic          r_post_split;
    rsa_pkg::t_slot r_post_slot;
    logic [LW-1:0] r_post_link;
    logic [IW-1:0] r_post_addr;
    logic          post_slot_we, post_link_we;
    logic [IW-1:0] post_link_addr;
    logic [LW-1:0] post_link_data;

    always_comb begin
        n_post = (r_state == rsa_pkg::S_SPLIT)
              || (r_state == rsa_pkg::S_UNLINK && r_prev != rsa_pkg::NO_LINK);
        post_slot_we   = r_post && r_post_split;
        post_link_we   = r_post;
        post_link_addr = r_post_addr;
        post_link_data = r_post_link;
    end

    always_ff @(posedge i_clk) begin
        r_post_split <= (r_state == rsa_pkg::S_SPLIT);
        if (r_state == rsa_pkg::S_SPLIT) begin
            r_post_addr <= r_spare[IW-1:0];
            r_post_link <= r_fnext;
            if (rem_h <= rem_w) begin
                r_post_slot <= '{x: rsa_pkg::sat_coord(SW'(r_fs.x) + SW'(r_pw)),
                                 y: r_fs.y,
                                 w: rsa_pkg::sat_dim(rem_w[DW-1:0]),
                                 h: r_fs.h};
            end else begin
                r_post_slot <= '{x: r_fs.x,
                                 y: rsa_pkg::sat_coord(SW'(r_fs.y) + SW'(r_ph)),
                                 w: r_fs.w,
                                 h: rsa_pkg::sat_dim(rem_h[DW-1:0])};
            end
        end else begin
            r_post_addr <= r_prev[IW-1:0];
            r_post_link <= r_fnext;
            r_post_slot <= r_fs;
        end
    end

    always_comb begin
        m_slot_we    = slot_we;
        m_slot_waddr = slot_waddr;
        m_slot_wdata = slot_wdata;
        m_link_we    = link_we;
        m_link_waddr = link_waddr;
        m_link_wdata = link_wdata;
        if (post_slot_we) begin
            m_slot_we    = 1'b1;
            m_slot_waddr = r_post_addr;
            m_slot_wdata = r_post_slot;
        end
        if (post_link_we) begin
            m_link_we    = 1'b1;
            m_link_waddr = post_link_addr;
            m_link_wdata = post_link_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsa_pkg::S_INIT;
            r_head  <= '0;
            r_spare <= LW'(1);
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_post  <= 1'b0;
            r_cur   <= '0;
            r_prev  <= rsa_pkg::NO_LINK;
            r_st    <= rsa_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_spare <= n_spare;
            r_cnt   <= (n_state == rsa_pkg::S_INIT && r_state == rsa_pkg::S_IDLE)
                     ? '0 : n_cnt;
            r_done  <= n_done;
            r_post  <= n_post;
            r_cur   <= n_cur;
            r_prev  <= n_prev;
            r_st    <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pw    <= n_pw;
        r_ph    <= n_ph;
        r_fs    <= n_fs;
        r_fnext <= n_fnext;
    end

    logic r_from_reset;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_from_reset <= 1'b1;
        end else if (r_state == rsa_pkg::S_DONE) begin
            r_from_reset <= 1'b0;
        end
    end

    rsa_pkg::t_slot r_res;
    logic [DW:0]    r_res_w, r_res_h;
    always_ff @(posedge i_clk) begin
        if (r_state == rsa_pkg::S_SPARE || r_state == rsa_pkg::S_IDLE
            || r_state == rsa_pkg::S_INIT) begin
            r_res   <= r_fs;
            r_res_w <= r_pw;
            r_res_h <= r_ph;
        end
    end

    assign o_busy        = (r_state != rsa_pkg::S_IDLE) || r_post;
    assign o_done        = r_done && !r_from_reset_q;
    assign o_status      = r_st_q;
    assign o_slot_x      = (r_st_q == rsa_pkg::ST_OK) ? r_res.x : '0;
    assign o_slot_y      = (r_st_q == rsa_pkg::ST_OK) ? r_res.y : '0;
    assign o_slot_width  = (r_st_q == rsa_pkg::ST_OK) ? r_res_w[DW-1:0] : '0;
    assign o_slot_height = (r_st_q == rsa_pkg::ST_OK) ? r_res_h[DW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_q         <= rsa_pkg::ST_OK;
            r_from_reset_q <= 1'b1;
        end else begin
            r_st_q         <= r_st;
            r_from_reset_q <= r_from_reset;
        end
    end

endmodule
